// ----- rtl/core/prgb_pkg.sv -----
package prgb_pkg;

  // Field widths of the stream words.
  localparam int OP_W    = 2;
  localparam int INDEX_W = 8;
  localparam int COLOR_W = 24;
  localparam int CODE_W  = 8;
  localparam int CHAN_W  = 8;

  // Default palette depth.
  localparam int DEFAULT_ENTRIES = 256;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
  localparam logic [OP_W-1:0] OP_READ       = 2'd1;
  localparam logic [OP_W-1:0] OP_BACKGROUND = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE      = 2'd3;

  // Luma weights, summing to 256.
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  // Pipeline advance strobes from the top level to the conversion stages.
  typedef struct packed {
    logic l_load;
    logic c_load;
  } prgb_adv_t;

  // Round an 8-bit channel to 3 bits: (v * 7 + 127) / 255.
  function automatic logic [2:0] round3(input logic [CHAN_W-1:0] v);
    logic [10:0] x;
    logic [2:0]  q;
    x = 11'(v) * 11'd7 + 11'd127;
    q = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      if (x >= 11'(255 * k)) begin
        q = q + 3'd1;
      end
    end
    return q;
  endfunction

  // Round an 8-bit channel to 2 bits: (v * 3 + 127) / 255.
  function automatic logic [1:0] round2(input logic [CHAN_W-1:0] v);
    logic [9:0] x;
    logic [1:0] q;
    x = 10'(v) * 10'd3 + 10'd127;
    q = 2'd0;
    for (int k = 1; k <= 3; k++) begin
      if (x >= 10'(255 * k)) begin
        q = q + 2'd1;
      end
    end
    return q;
  endfunction

  // Rounded replication of a 3-bit channel: (c * 255 + 3) / 7.
  function automatic logic [CHAN_W-1:0] expand3(input logic [2:0] c);
    logic [CHAN_W-1:0] v;
    unique case (c)
      3'd0: v = 8'd0;
      3'd1: v = 8'd36;
      3'd2: v = 8'd73;
      3'd3: v = 8'd109;
      3'd4: v = 8'd146;
      3'd5: v = 8'd182;
      3'd6: v = 8'd219;
      3'd7: v = 8'd255;
    endcase
    return v;
  endfunction

  // Rounded replication of a 2-bit channel: (c * 255 + 1) / 3.
  function automatic logic [CHAN_W-1:0] expand2(input logic [1:0] c);
    logic [CHAN_W-1:0] v;
    unique case (c)
      2'd0: v = 8'd0;
      2'd1: v = 8'd85;
      2'd2: v = 8'd170;
      2'd3: v = 8'd255;
    endcase
    return v;
  endfunction

  // Expand an RRRGGGBB code back to RGB888.
  function automatic logic [COLOR_W-1:0] expand_code(input logic [CODE_W-1:0] p);
    return {expand3(p[7:5]), expand3(p[4:2]), expand2(p[1:0])};
  endfunction

endpackage

// ----- rtl/core/palette_rgb332_engine_core.sv -----
// Palette of PALETTE_ENTRIES RGB888 colors with RGB332 conversion. Each input word
// writes an entry, reads one, or sets the background (entry zero, whose code is
// latched as the border pixel), and gives one output word with the stored color,
// its rounded RGB332 code (after luma grey when greyscale is on), the code expanded
// back to RGB888, and the border code. The block takes one word per cycle while
// the output is not stalled. Each accepted word passes the palette RAM read
// register, which loads at the accepting edge, then the luma/channel register,
// and the rounded code then enters the output register.
// A stalled output lets the earlier stages fill, so up to three words wait inside
// before the input is held. Entries come out of reset as zero through per-entry
// valid bits, so no clearing pass is needed.
// Indexes at or above PALETTE_ENTRIES are not written and read as zero.
module palette_rgb332_engine_core #(
  parameter int PALETTE_ENTRIES = prgb_pkg::DEFAULT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,  // greyscale_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // entry_index[7:0], new_color[31:8]
  input  logic [1:0]  s_tuser,    // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata     // stored_color[23:0], pixel_code[31:24],
                                  // expanded_color[55:32], border_code[63:56]
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic                                 grey;
  logic [prgb_pkg::OP_W-1:0]            op;
  logic [prgb_pkg::INDEX_W-1:0]         idx;
  logic [prgb_pkg::COLOR_W-1:0]         new_color;
  logic                                 is_bg;
  logic                                 is_write;
  logic                                 hit;
  logic [AW-1:0]                        addr;
  logic                                 accept;
  logic [PALETTE_ENTRIES-1:0]           live;
  logic                                 b_valid;
  logic                                 b_bg;
  logic                                 b_hit;
  logic [prgb_pkg::COLOR_W-1:0]         ram_rdata;
  logic [prgb_pkg::COLOR_W-1:0]         b_stored;
  logic                                 l_valid;
  logic                                 out_free;
  prgb_pkg::prgb_adv_t                  adv;
  logic [prgb_pkg::COLOR_W-1:0]         stored_color;
  logic [prgb_pkg::CODE_W-1:0]          pixel_code;
  logic [prgb_pkg::COLOR_W-1:0]         expanded_color;
  logic [prgb_pkg::CODE_W-1:0]          border_code;

  // Greyscale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grey <= 1'b0;
    end else if (cfg_we) begin
      grey <= cfg_wdata;
    end
  end

  // Decode of the input word; background always targets entry zero.
  always_comb begin
    op        = s_tuser;
    new_color = s_tdata[31:8];
    is_bg     = (op == prgb_pkg::OP_BACKGROUND);
    is_write  = (op == prgb_pkg::OP_WRITE) || is_bg;
    idx       = is_bg ? '0 : s_tdata[7:0];
    hit       = (9'(idx) < 9'(PALETTE_ENTRIES));
    addr      = idx[AW-1:0];
  end

  // Pipeline advance: output register, channel stage, RAM data stage.
  always_comb begin
    out_free   = !m_tvalid || m_tready;
    adv.c_load = l_valid && out_free;
    adv.l_load = b_valid && (!l_valid || adv.c_load);
    s_tready   = !b_valid || adv.l_load;
    accept     = s_tvalid && s_tready;
  end

  // Per-entry valid bits stand in for clearing the RAM at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (accept && hit && is_write) begin
      live[addr] <= 1'b1;
    end
  end

  prgb_ram #(
    .WIDTH (prgb_pkg::COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .en    (accept && hit),
    .we    (is_write),
    .addr  (addr),
    .wdata (new_color),
    .rdata (ram_rdata)
  );

  // RAM data stage bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (adv.l_load) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_bg  <= is_bg;
      b_hit <= hit && (is_write || live[addr]);
    end
  end

  // Unwritten or out-of-range entries read as zero.
  assign b_stored = b_hit ? ram_rdata : '0;

  // Channel stage and output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv.l_load) begin
        l_valid <= 1'b1;
      end else if (adv.c_load) begin
        l_valid <= 1'b0;
      end
      if (adv.c_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  prgb_convert u_convert (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .grey           (grey),
    .b_stored       (b_stored),
    .b_bg           (b_bg),
    .stored_color   (stored_color),
    .pixel_code     (pixel_code),
    .expanded_color (expanded_color),
    .border_code    (border_code)
  );

  assign m_tdata = {border_code, expanded_color, pixel_code, stored_color};

endmodule

// ----- rtl/core/prgb_ram.sv -----
module prgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, write-first; read data holds while the port is idle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
        rdata     <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/core/prgb_convert.sv -----
module prgb_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  prgb_pkg::prgb_adv_t           adv,
  input  logic                          grey,
  input  logic [prgb_pkg::COLOR_W-1:0]  b_stored,
  input  logic                          b_bg,
  output logic [prgb_pkg::COLOR_W-1:0]  stored_color,
  output logic [prgb_pkg::CODE_W-1:0]   pixel_code,
  output logic [prgb_pkg::COLOR_W-1:0]  expanded_color,
  output logic [prgb_pkg::CODE_W-1:0]   border_code
);

  logic [prgb_pkg::COLOR_W-1:0] l_stored;
  logic [prgb_pkg::CHAN_W-1:0]  l_r;
  logic [prgb_pkg::CHAN_W-1:0]  l_g;
  logic [prgb_pkg::CHAN_W-1:0]  l_b;
  logic                         l_bg;
  logic [15:0]                  luma_sum;
  logic [prgb_pkg::CHAN_W-1:0]  luma;
  logic [prgb_pkg::CODE_W-1:0]  code;
  logic [prgb_pkg::CODE_W-1:0]  border;

  // Luma weighting of the stored color; the weights sum to 256.
  always_comb begin
    luma_sum = 16'(b_stored[23:16]) * 16'(prgb_pkg::LUMA_R)
             + 16'(b_stored[15:8])  * 16'(prgb_pkg::LUMA_G)
             + 16'(b_stored[7:0])   * 16'(prgb_pkg::LUMA_B);
    luma     = luma_sum[15:8];
  end

  // Channel stage: either the color itself or its grey.
  always_ff @(posedge clk) begin
    if (adv.l_load) begin
      l_stored <= b_stored;
      l_bg     <= b_bg;
      if (grey) begin
        l_r <= luma;
        l_g <= luma;
        l_b <= luma;
      end else begin
        l_r <= b_stored[23:16];
        l_g <= b_stored[15:8];
        l_b <= b_stored[7:0];
      end
    end
  end

  // 3-3-2 rounding.
  assign code = {prgb_pkg::round3(l_r), prgb_pkg::round3(l_g), prgb_pkg::round2(l_b)};

  // Border pixel latched by a background set.
  always_ff @(posedge clk) begin
    if (rst) begin
      border <= '0;
    end else if (adv.c_load && l_bg) begin
      border <= code;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (adv.c_load) begin
      stored_color   <= l_stored;
      pixel_code     <= code;
      expanded_color <= prgb_pkg::expand_code(code);
      border_code    <= l_bg ? code : border;
    end
  end

endmodule

// ----- rtl/core/prgb_checker.sv -----
module prgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // A result waiting at the output stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word present after reset");

  // The expanded color always matches the code it came from.
  a_expand: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:32] == prgb_pkg::expand_code(m_tdata[31:24]))
    else $error("expanded color does not match pixel code");

  // Black converts to code zero in either mode.
  a_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[23:0] == 24'd0) |-> m_tdata[31:24] == 8'd0)
    else $error("black entry gave a nonzero code");

endmodule

bind palette_rgb332_engine_core prgb_checker u_prgb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
